[hdl/rate_monotonic_task_scheduler_assert.svh]
// Assertion macros for the rate monotonic task scheduler.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef RATE_MONOTONIC_TASK_SCHEDULER_ASSERT_SVH
`define RATE_MONOTONIC_TASK_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define RMTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RMTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RMTS_ASSERT(lbl, prop, msg)
`define RMTS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hdl/rmts_pkg.sv]
// Shared types and constants of the rate monotonic task scheduler.
// No dependencies.
package rmts_pkg;

  localparam int TIME_BITS  = 32;
  localparam int FIELD_BITS = 16;
  localparam int ID_BITS    = 3;

  typedef logic [1:0] status_t;

  localparam status_t ST_READY   = 2'd0;
  localparam status_t ST_BLOCKED = 2'd1;
  localparam status_t ST_DONE    = 2'd2;
  localparam status_t ST_RUNNING = 2'd3;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

endpackage

[hdl/rate_monotonic_task_scheduler.sv]
// Rate monotonic task scheduler: task table, tick walker and phase divider.
// Depends on rmts_pkg and rate_monotonic_task_scheduler_assert.svh.
//
//   channel | dir | tdata fields (low bit up)                          | tuser
//   --------+-----+----------------------------------------------------+------
//   in_     | in  | task_period[15:0] task_capacity[31:16] start_blocked[32] | mode
//   out_    | out | accepted[0] task_id[3:1] idle_runs[4]              | -
//
// One item at a time; in_tready is high only while nothing is in flight.
// Tick: walks every stored task from accept back to ready, reading each table
//   entry through the single registered read port of the task table.
// Accepted add: runs the 32-step restoring divider that works out the task's
//   phase (time mod period). Rejected add: answered straight from idle.
// Reset (synchronous, rst_n low) clears control state only; table entries are
//   only ever read below the stored count. The result holds while out_tready
//   is low.
module rate_monotonic_task_scheduler #(
  parameter int MAX_TASKS   = 8,
  parameter int PERIOD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // task_period[15:0], task_capacity[31:16],
                                  // start_blocked[32], zero pad[39:33]
  input  logic        in_tuser,   // mode (0 add, 1 tick)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // accepted[0], task_id[3:1], idle_runs[4],
                                  // zero pad[7:5]
);

  // stored period width: low PERIOD_BITS bits of the 16-bit field, at most all 16
  localparam int SPW = (PERIOD_BITS < rmts_pkg::FIELD_BITS) ? PERIOD_BITS
                                                           : rmts_pkg::FIELD_BITS;
  localparam int IW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int SW  = $clog2(MAX_TASKS + 1);
  localparam int DCW = $clog2(rmts_pkg::TIME_BITS);
  localparam int FW  = rmts_pkg::FIELD_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_ADDW  = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_EVAL  = 3'd5;
  localparam logic [2:0] S_FINRD = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  // ---------------------------------------------------------------- control
  logic [2:0]             state_r, state_nxt;
  logic                   res_pend_r, res_pend_nxt;
  logic [SW-1:0]          stored_r, stored_nxt;
  logic [IW-1:0]          cur_r, cur_nxt;
  logic                   idle_r, idle_nxt;
  logic [rmts_pkg::TIME_BITS-1:0] time_r, time_nxt;
  logic [SW-1:0]          walk_r, walk_nxt;
  logic [DCW-1:0]         dcnt_r, dcnt_nxt;
  logic [PERIOD_BITS-1:0] best_r, best_nxt;

  // ---------------------------------------------------------------- payload
  logic [SPW-1:0]         per_r, per_nxt;
  logic [FW-1:0]          cap_r, cap_nxt;
  logic                   blk_r, blk_nxt;
  logic [SPW-1:0]         rem_r, rem_nxt;
  logic                   o_acc_r, o_acc_nxt;
  logic [rmts_pkg::ID_BITS-1:0] o_id_r, o_id_nxt;
  logic                   o_idle_r, o_idle_nxt;

  // ---------------------------------------------------------------- tables
  logic [SPW-1:0]          period_mem_r [MAX_TASKS];
  logic [FW-1:0]           cap_mem_r    [MAX_TASKS];
  logic [FW-1:0]           used_mem_r   [MAX_TASKS];
  rmts_pkg::status_t       stat_mem_r   [MAX_TASKS];
  logic [SPW-1:0]          phase_mem_r  [MAX_TASKS];

  logic [SPW-1:0]          period_rd_r;
  logic [FW-1:0]           cap_rd_r;
  logic [FW-1:0]           used_rd_r;
  rmts_pkg::status_t       stat_rd_r;
  logic [SPW-1:0]          phase_rd_r;

  logic [IW-1:0]           rd_addr, wr_addr;
  logic                    period_we, cap_we, used_we, stat_we, phase_we;
  logic [FW-1:0]           used_wd;
  rmts_pkg::status_t       stat_wd;
  logic [SPW-1:0]          phase_wd;

  // ---------------------------------------------------------------- helpers
  logic                    in_beat, out_beat;
  logic [SPW-1:0]          in_per;
  logic [FW-1:0]           in_cap;
  logic                    add_ok;
  logic [SPW:0]            rem_sh;
  logic [SPW:0]            rem_sub;
  logic [SPW:0]            phase_inc;
  logic [PERIOD_BITS-1:0]  period_ext;
  logic                    cur_live;
  logic [IW+2:0]           cur_wide;
  logic [SW+2:0]           stored_wide;

  assign in_tready  = (state_r == S_IDLE) && !res_pend_r;
  assign out_tvalid = res_pend_r;
  assign out_tdata  = {3'b000, o_idle_r, o_id_r, o_acc_r};
  assign in_beat    = in_tvalid && in_tready;
  assign out_beat   = out_tvalid && out_tready;

  assign in_per  = in_tdata[SPW-1:0];
  assign in_cap  = in_tdata[2*FW-1:FW];
  // add rejected on zero period or capacity, period below capacity, or a full table
  assign add_ok  = (in_per != '0) && (in_cap != '0) && (FW'(in_per) >= in_cap) &&
                   (stored_r < SW'(MAX_TASKS));

  // one restoring step of time mod period, time bits MSB first
  assign rem_sh  = {rem_r, time_r[~dcnt_r]};
  assign rem_sub = rem_sh - {1'b0, per_r};

  // phase tracks time mod period; the 32-bit wrap sends every phase to zero
  assign phase_inc  = {1'b0, phase_rd_r} + {{SPW{1'b0}}, 1'b1};
  assign period_ext = PERIOD_BITS'(period_rd_r);
  assign cur_live   = !idle_r && (SW'(cur_r) < stored_r);
  assign cur_wide    = (IW + 3)'(cur_r);
  assign stored_wide = (SW + 3)'(stored_r);

  always_comb begin
    case (state_r)
      S_RD:    rd_addr = walk_r[IW-1:0];
      default: rd_addr = cur_r;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    res_pend_nxt = res_pend_r;
    stored_nxt   = stored_r;
    cur_nxt      = cur_r;
    idle_nxt     = idle_r;
    time_nxt     = time_r;
    walk_nxt     = walk_r;
    dcnt_nxt     = dcnt_r;
    best_nxt     = best_r;
    per_nxt      = per_r;
    cap_nxt      = cap_r;
    blk_nxt      = blk_r;
    rem_nxt      = rem_r;
    o_acc_nxt    = o_acc_r;
    o_id_nxt     = o_id_r;
    o_idle_nxt   = o_idle_r;
    wr_addr      = cur_r;
    period_we    = 1'b0;
    cap_we       = 1'b0;
    used_we      = 1'b0;
    stat_we      = 1'b0;
    phase_we     = 1'b0;
    used_wd      = '0;
    stat_wd      = rmts_pkg::ST_READY;
    phase_wd     = '0;

    if (out_beat) begin
      res_pend_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          per_nxt = in_per;
          cap_nxt = in_cap;
          blk_nxt = in_tdata[2*FW];
          if (in_tuser == rmts_pkg::MODE_TICK) begin
            state_nxt = S_CHK;
          end else if (add_ok) begin
            rem_nxt   = '0;
            dcnt_nxt  = '0;
            state_nxt = S_DIV;
          end else begin
            o_acc_nxt    = 1'b0;
            o_id_nxt     = '0;
            o_idle_nxt   = 1'b0;
            res_pend_nxt = 1'b1;
          end
        end
      end
      S_DIV: begin
        rem_nxt  = rem_sub[SPW] ? rem_sh[SPW-1:0] : rem_sub[SPW-1:0];
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == '1) begin
          state_nxt = S_ADDW;
        end
      end
      S_ADDW: begin
        wr_addr      = stored_r[IW-1:0];
        period_we    = 1'b1;
        cap_we       = 1'b1;
        used_we      = 1'b1;
        stat_we      = 1'b1;
        phase_we     = 1'b1;
        used_wd      = '0;
        stat_wd      = blk_r ? rmts_pkg::ST_BLOCKED : rmts_pkg::ST_READY;
        phase_wd     = rem_r;
        stored_nxt   = stored_r + 1'b1;
        o_acc_nxt    = 1'b1;
        o_id_nxt     = stored_wide[2:0];
        o_idle_nxt   = 1'b0;
        res_pend_nxt = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_CHK: begin
        // running task out of budget: done, idle takes over; else its period is the bar to beat
        best_nxt = '1;
        if (cur_live) begin
          if (used_rd_r == cap_rd_r) begin
            stat_we  = 1'b1;
            stat_wd  = rmts_pkg::ST_DONE;
            idle_nxt = 1'b1;
          end else begin
            best_nxt = period_ext;
          end
        end
        walk_nxt  = '0;
        state_nxt = (stored_r == '0) ? S_FINRD : S_RD;
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        wr_addr  = walk_r[IW-1:0];
        phase_we = 1'b1;
        phase_wd = ((time_r == '1) || (phase_inc == {1'b0, period_rd_r})) ?
                   '0 : phase_inc[SPW-1:0];
        if (stat_rd_r != rmts_pkg::ST_BLOCKED &&
            (stat_rd_r != rmts_pkg::ST_DONE || phase_rd_r == '0)) begin
          if (stat_rd_r == rmts_pkg::ST_DONE) begin
            used_we = 1'b1;
            used_wd = '0;
            stat_we = 1'b1;
            stat_wd = rmts_pkg::ST_READY;
          end
          if (period_ext < best_r) begin
            best_nxt = period_ext;
            cur_nxt  = walk_r[IW-1:0];
            idle_nxt = 1'b0;
          end
        end
        walk_nxt  = walk_r + 1'b1;
        state_nxt = ((walk_r + 1'b1) == stored_r) ? S_FINRD : S_RD;
      end
      S_FINRD: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        o_acc_nxt = 1'b1;
        if (cur_live) begin
          stat_we    = 1'b1;
          stat_wd    = rmts_pkg::ST_RUNNING;
          used_we    = 1'b1;
          used_wd    = used_rd_r + 1'b1;
          o_id_nxt   = cur_wide[2:0];
          o_idle_nxt = 1'b0;
        end else begin
          idle_nxt   = 1'b1;
          o_id_nxt   = '0;
          o_idle_nxt = 1'b1;
        end
        time_nxt     = time_r + 1'b1;
        res_pend_nxt = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      res_pend_r <= 1'b0;
      stored_r   <= '0;
      cur_r      <= '0;
      idle_r     <= 1'b1;
      time_r     <= '0;
      walk_r     <= '0;
      dcnt_r     <= '0;
      best_r     <= '1;
    end else begin
      state_r    <= state_nxt;
      res_pend_r <= res_pend_nxt;
      stored_r   <= stored_nxt;
      cur_r      <= cur_nxt;
      idle_r     <= idle_nxt;
      time_r     <= time_nxt;
      walk_r     <= walk_nxt;
      dcnt_r     <= dcnt_nxt;
      best_r     <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    per_r    <= per_nxt;
    cap_r    <= cap_nxt;
    blk_r    <= blk_nxt;
    rem_r    <= rem_nxt;
    o_acc_r  <= o_acc_nxt;
    o_id_r   <= o_id_nxt;
    o_idle_r <= o_idle_nxt;
  end

  // table memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (period_we) begin
      period_mem_r[wr_addr] <= per_r;
    end
    period_rd_r <= period_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_mem_r[wr_addr] <= cap_r;
    end
    cap_rd_r <= cap_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem_r[wr_addr] <= used_wd;
    end
    used_rd_r <= used_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem_r[wr_addr] <= stat_wd;
    end
    stat_rd_r <= stat_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (phase_we) begin
      phase_mem_r[wr_addr] <= phase_wd;
    end
    phase_rd_r <= phase_mem_r[rd_addr];
  end

  // ---------------------------------------------------------------- checks
`include "rate_monotonic_task_scheduler_assert.svh"

  `RMTS_ASSERT(a_no_accept_while_result, !(in_tready && out_tvalid), "ready with result pending")
  `RMTS_ASSERT(a_stored_bound, stored_r <= SW'(MAX_TASKS), "task count beyond table depth")
  `RMTS_ASSERT(a_stored_step, $past(rst_n) && (stored_r != $past(stored_r)) |-> (stored_r == $past(stored_r) + 1'b1) && out_tvalid, "task count moved without an add result")
  `RMTS_ASSERT(a_time_step, $past(rst_n) && (time_r != $past(time_r)) |-> out_tvalid && o_acc_r && !$past(out_tvalid), "time advanced outside a tick")

endmodule
